// ===== hdl/pf_enc_pkg.sv =====
// Shared types, codes and helper functions for the Playfair encipher block.
`timescale 1ns / 1ps

package pf_enc_pkg;

  // Input action codes
  localparam logic [1:0] ACT_KEY    = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_TEXT   = 2'd2;
  localparam logic [1:0] ACT_FLUSH  = 2'd3;

  // Square geometry
  localparam int SIDE    = 5;
  localparam int CELLS   = 25;
  localparam int LETTERS = 26;

  typedef logic [4:0] letter_t;  // letter index, A = 0
  typedef logic [2:0] coord_t;   // row or column, 0..4

  localparam letter_t IDX_I    = 5'd8;
  localparam letter_t IDX_J    = 5'd9;
  localparam letter_t IDX_X    = 5'd23;
  localparam letter_t IDX_LAST = 5'(LETTERS - 1);

  localparam logic [6:0] ASCII_A = 7'd65;

  typedef struct packed {
    logic    valid;
    letter_t idx;
  } letter_dec_t;

  // Map a raw byte to a letter index, either case
  function automatic letter_dec_t decode_letter(logic [7:0] b);
    letter_dec_t r;
    r.valid = 1'b0;
    r.idx   = '0;
    if (b >= 8'd65 && b <= 8'd90) begin
      r.valid = 1'b1;
      r.idx   = 5'(b - 8'd65);
    end else if (b >= 8'd97 && b <= 8'd122) begin
      r.valid = 1'b1;
      r.idx   = 5'(b - 8'd97);
    end
    return r;
  endfunction

  // Step a row or column by one, wrapping around the square
  function automatic coord_t inc_mod_side(coord_t v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : 3'(v + 3'd1);
  endfunction

  // Cell address row * 5 + column
  function automatic letter_t cell_addr(coord_t r, coord_t c);
    return 5'({r, 2'b00}) + 5'({2'b00, r}) + 5'({2'b00, c});
  endfunction

endpackage

// ===== hdl/pf_enc_in_if.sv =====
// Input channel: action code and raw byte with valid/ready handshake.
`timescale 1ns / 1ps

interface pf_enc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] byte_in;

  modport source (output valid, output action, output byte_in, input ready);
  modport sink   (input valid, input action, input byte_in, output ready);
endinterface

// ===== hdl/pf_enc_out_if.sv =====
// Output channel: one cipher letter per transfer with valid/ready handshake.
`timescale 1ns / 1ps

interface pf_enc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cipher_letter;
  logic       pair_last;

  modport source (output valid, output cipher_letter, output pair_last, input ready);
  modport sink   (input valid, input cipher_letter, input pair_last, output ready);
endinterface

// ===== hdl/playfair_encipher.sv =====
// A text or flush item ending a pair: place read, cell read, then its first letter is shown.
// A pair goes through accept, cell read and two letter transfers; the output can stall them.
// Key bytes are placed as accepted; finish sweeps all 26 letters through the write port.
// One item is in work at a time; the square and position memories have one write port.
// Reset clears control, fill count, used flags and the held letter; memories are not cleared.
// Position entries are written as letters are placed, so no clearing pass is needed.
`timescale 1ns / 1ps

module playfair_encipher
  import pf_enc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  pf_enc_in_if.sink     in_i,
  pf_enc_out_if.source  out_o
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_CELL = 3'd2;
  localparam logic [2:0] ST_OUT0 = 3'd3;
  localparam logic [2:0] ST_OUT1 = 3'd4;

  logic [2:0]         state_q, state_d;
  letter_t            sweep_q, sweep_d;
  letter_t            fill_q;
  coord_t             fill_row_q, fill_col_q;
  logic [LETTERS-1:0] used_q;
  letter_t            held_q, held_d;
  logic               held_valid_q, held_valid_d;

  // Memories: square cells and the {row, column} place of each letter
  letter_t            sq_mem  [CELLS];
  logic [5:0]         pos_mem [LETTERS];
  logic [5:0]         pos_rd0_q, pos_rd1_q;
  letter_t            sq_rd0_q, sq_rd1_q;

  logic               in_xfer, out_xfer;
  letter_dec_t        dec;
  letter_t            key_letter;
  letter_t            cand;
  logic               cand_ok, place_en;
  logic               pair_go;
  letter_t            pair_a, pair_b, pos_addr0, pos_addr1;
  coord_t             r1, c1, r2, c2;
  letter_t            sq_addr0, sq_addr1;

  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;
  assign dec        = decode_letter(in_i.byte_in);
  assign key_letter = (dec.idx == IDX_J) ? IDX_I : dec.idx;

  // Control: letter placement, pairing and sequencing
  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    cand         = sweep_q;
    cand_ok      = 1'b0;
    pair_go      = 1'b0;
    pair_a       = held_q;
    pair_b       = IDX_X;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_i.action)
            ACT_KEY: begin
              cand    = key_letter;
              cand_ok = dec.valid;
            end
            ACT_FINISH: begin
              sweep_d = '0;
              state_d = ST_FILL;
            end
            ACT_TEXT: begin
              if (dec.valid) begin
                if (!held_valid_q) begin
                  held_d       = dec.idx;
                  held_valid_d = 1'b1;
                end else if (dec.idx == held_q) begin
                  // doubled letter: pad with X, keep the new one held
                  pair_go = 1'b1;
                end else begin
                  pair_b       = dec.idx;
                  pair_go      = 1'b1;
                  held_valid_d = 1'b0;
                end
              end
            end
            ACT_FLUSH: begin
              if (held_valid_q) begin
                pair_go      = 1'b1;
                held_valid_d = 1'b0;
              end
            end
            default: ;
          endcase
          if (pair_go) begin
            state_d = ST_CELL;
          end
        end
      end
      ST_FILL: begin
        cand    = sweep_q;
        cand_ok = (sweep_q != IDX_J);
        sweep_d = 5'(sweep_q + 5'd1);
        if (sweep_q == IDX_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_CELL: state_d = ST_OUT0;
      ST_OUT0: if (out_xfer) state_d = ST_OUT1;
      ST_OUT1: if (out_xfer) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign place_en  = cand_ok && (fill_q < 5'(CELLS)) && !used_q[cand];
  // J shares the place of I
  assign pos_addr0 = (pair_a == IDX_J) ? IDX_I : pair_a;
  assign pos_addr1 = (pair_b == IDX_J) ? IDX_I : pair_b;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      sweep_q      <= '0;
      fill_q       <= '0;
      fill_row_q   <= '0;
      fill_col_q   <= '0;
      used_q       <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      if (place_en) begin
        used_q[cand] <= 1'b1;
        fill_q       <= 5'(fill_q + 5'd1);
        if (fill_col_q == 3'(SIDE - 1)) begin
          fill_col_q <= '0;
          fill_row_q <= 3'(fill_row_q + 3'd1);
        end else begin
          fill_col_q <= 3'(fill_col_q + 3'd1);
        end
      end
    end
  end

  // Place lookup for the pair, then cell addresses by rule
  always_comb begin
    r1 = pos_rd0_q[5:3];
    c1 = pos_rd0_q[2:0];
    r2 = pos_rd1_q[5:3];
    c2 = pos_rd1_q[2:0];
    if (r1 == r2) begin
      sq_addr0 = cell_addr(r1, inc_mod_side(c1));
      sq_addr1 = cell_addr(r1, inc_mod_side(c2));
    end else if (c1 == c2) begin
      sq_addr0 = cell_addr(inc_mod_side(r1), c1);
      sq_addr1 = cell_addr(inc_mod_side(r2), c1);
    end else begin
      sq_addr0 = cell_addr(r1, c2);
      sq_addr1 = cell_addr(r2, c1);
    end
  end

  // Memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      sq_mem[fill_q] <= cand;
      pos_mem[cand]  <= {fill_row_q, fill_col_q};
    end
    if (pair_go) begin
      pos_rd0_q <= pos_mem[pos_addr0];
      pos_rd1_q <= pos_mem[pos_addr1];
    end
    if (state_q == ST_CELL) begin
      sq_rd0_q <= sq_mem[sq_addr0];
      sq_rd1_q <= sq_mem[sq_addr1];
    end
  end

  // Ports
  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = (state_q == ST_OUT0) || (state_q == ST_OUT1);
  assign out_o.pair_last     = (state_q == ST_OUT1);
  assign out_o.cipher_letter = ASCII_A
                             + {2'b00, (state_q == ST_OUT1) ? sq_rd1_q : sq_rd0_q};

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 5'(CELLS))
    else $error("fill count beyond square size");

  a_fill_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(fill_q))
    else $error("used flags disagree with fill count");

  a_fill_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == cell_addr(fill_row_q, fill_col_q))
    else $error("fill row/column out of step with fill count");

  a_sweep_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && sweep_q == IDX_LAST) |=> fill_q == 5'(CELLS))
    else $error("finish sweep left the square short");

  a_cell_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CELL) |=> (state_q == ST_OUT0 && out_o.pair_last == 1'b0))
    else $error("cell read not followed by first letter");
`endif

endmodule
